FILE: src/rca_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rca_pkg: shared types and constants of the RGBA8 channel ALU
// Holds the mode codes, the per-lane operation type, and the mode decoder
// that maps a mode and a lane index to the operation that lane performs.
// ----------------------------------------------------------------------------
package rca_pkg;

  localparam int unsigned CH_W     = 8;
  localparam int unsigned LANES    = 4;
  localparam int unsigned COLOR_W  = CH_W * LANES;
  localparam int unsigned MODE_W   = 4;
  localparam int unsigned FACTOR_W = 9;
  localparam int unsigned LANE_W   = $clog2(LANES);

  localparam logic [LANE_W-1:0] LANE_ALPHA = LANE_W'(LANES - 1);

  // Mode codes as carried on the input channel
  localparam logic [MODE_W-1:0] MODE_ADD       = 4'd0;
  localparam logic [MODE_W-1:0] MODE_ADD_RGB   = 4'd1;
  localparam logic [MODE_W-1:0] MODE_ADD_A     = 4'd2;
  localparam logic [MODE_W-1:0] MODE_SUB       = 4'd3;
  localparam logic [MODE_W-1:0] MODE_SUB_RGB   = 4'd4;
  localparam logic [MODE_W-1:0] MODE_SUB_A     = 4'd5;
  localparam logic [MODE_W-1:0] MODE_MOD       = 4'd6;
  localparam logic [MODE_W-1:0] MODE_MOD_RGB   = 4'd7;
  localparam logic [MODE_W-1:0] MODE_MOD_A     = 4'd8;
  localparam logic [MODE_W-1:0] MODE_LERP_S    = 4'd9;
  localparam logic [MODE_W-1:0] MODE_LERP_C    = 4'd10;
  localparam logic [MODE_W-1:0] MODE_REPL_A    = 4'd11;

  typedef logic [MODE_W-1:0]   mode_t;
  typedef logic [COLOR_W-1:0]  color_t;
  typedef logic [FACTOR_W-1:0] factor_t;
  typedef logic [CH_W-1:0]     chan_t;

  // Operation performed by a single channel lane
  typedef enum logic [2:0] {
    OP_PASS,
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_LERP_S,
    OP_LERP_C,
    OP_REPL
  } rca_op_t;

  // Map a mode and a lane to the lane operation; unselected lanes pass
  function automatic rca_op_t rca_decode(mode_t mode, logic [LANE_W-1:0] lane);
    logic    is_a;
    rca_op_t op;
    is_a = (lane == LANE_ALPHA);
    case (mode)
      MODE_ADD:     op = OP_ADD;
      MODE_ADD_RGB: op = is_a ? OP_PASS : OP_ADD;
      MODE_ADD_A:   op = is_a ? OP_ADD : OP_PASS;
      MODE_SUB:     op = OP_SUB;
      MODE_SUB_RGB: op = is_a ? OP_PASS : OP_SUB;
      MODE_SUB_A:   op = is_a ? OP_SUB : OP_PASS;
      MODE_MOD:     op = OP_MUL;
      MODE_MOD_RGB: op = is_a ? OP_PASS : OP_MUL;
      MODE_MOD_A:   op = is_a ? OP_MUL : OP_PASS;
      MODE_LERP_S:  op = OP_LERP_S;
      MODE_LERP_C:  op = OP_LERP_C;
      MODE_REPL_A:  op = OP_REPL;
      default:      op = OP_PASS;
    endcase
    return op;
  endfunction

endpackage
`default_nettype wire

FILE: src/rca_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rca_in_if: input channel of the RGBA8 channel ALU
// Valid/ready channel carrying the mode, three colours and a Q1.8 factor.
// ----------------------------------------------------------------------------
interface rca_in_if;
  import rca_pkg::*;

  logic    valid;
  logic    ready;
  mode_t   mode;
  color_t  first_colour;
  color_t  second_colour;
  color_t  factor_colour;
  factor_t blend_factor;

  modport source (
    output valid, mode, first_colour, second_colour, factor_colour, blend_factor,
    input  ready
  );

  modport sink (
    input  valid, mode, first_colour, second_colour, factor_colour, blend_factor,
    output ready
  );
endinterface
`default_nettype wire

FILE: src/rca_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rca_out_if: result channel of the RGBA8 channel ALU
// Valid/ready channel carrying one packed RGBA8 result colour.
// ----------------------------------------------------------------------------
interface rca_out_if;
  import rca_pkg::*;

  logic   valid;
  logic   ready;
  color_t result_colour;

  modport source (
    output valid, result_colour,
    input  ready
  );

  modport sink (
    input  valid, result_colour,
    output ready
  );
endinterface
`default_nettype wire

FILE: src/rca_lane.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rca_lane: one 8-bit channel of the RGBA8 channel ALU
// Combinational: saturating add/sub; modulate and both interpolations share
// a single signed multiplier; divide by 255 is a shift-add with correction.
// ----------------------------------------------------------------------------
module rca_lane (
  input  wire rca_pkg::rca_op_t op,
  input  wire rca_pkg::chan_t   a_ch,
  input  wire rca_pkg::chan_t   b_ch,
  input  wire rca_pkg::chan_t   c_ch,
  input  wire rca_pkg::chan_t   alpha_ch,
  input  wire rca_pkg::factor_t blend_factor,
  output rca_pkg::chan_t        result_ch
);
  import rca_pkg::*;

  logic               is_mul;
  logic signed [8:0]  diff;
  factor_t            fac;
  logic signed [9:0]  op1;
  logic signed [9:0]  op2;
  logic signed [19:0] prod;
  logic signed [19:0] prod_shr;
  logic signed [11:0] lerp_s_sum;
  chan_t              lerp_s_res;
  logic [19:0]        prod_neg;
  logic               neg;
  logic [15:0]        mag;
  logic [16:0]        div_in;
  logic [16:0]        div_y;
  logic [16:0]        div_q;
  chan_t              quo;
  logic signed [9:0]  quo_s;
  logic signed [9:0]  lerp_c_sum;
  logic [CH_W:0]      add_sum;
  chan_t              add_res;
  chan_t              sub_res;

  // Share one multiplier: a*b for modulate, (b-a)*factor for interpolation
  assign is_mul = (op == OP_MUL);
  assign diff   = $signed({1'b0, b_ch}) - $signed({1'b0, a_ch});
  assign fac    = (op == OP_LERP_C) ? {1'b0, c_ch} : blend_factor;
  assign op1    = is_mul ? $signed({2'b00, a_ch}) : $signed({diff[8], diff});
  assign op2    = is_mul ? $signed({2'b00, b_ch}) : $signed({1'b0, fac});
  assign prod   = op1 * op2;

  // Scalar lerp: floor divide by 256 is an arithmetic shift, then clamp
  assign prod_shr   = prod >>> 8;
  assign lerp_s_sum = $signed({4'b0000, a_ch}) + $signed(prod_shr[11:0]);

  always_comb begin
    if (lerp_s_sum[11]) begin
      lerp_s_res = '0;
    end else if (lerp_s_sum > 12'sd255) begin
      lerp_s_res = '1;
    end else begin
      lerp_s_res = lerp_s_sum[CH_W-1:0];
    end
  end

  // Per-channel lerp: floor(n/255); negative n uses -floor((|n|+254)/255)
  assign prod_neg = 20'(-prod);
  assign neg      = prod[19];
  assign mag      = neg ? prod_neg[15:0] : prod[15:0];
  assign div_in   = {1'b0, mag} + (neg ? 17'd254 : 17'd0);
  assign div_y    = div_in + 17'd1;
  assign div_q    = (div_y + (div_y >> 8)) >> 8;
  assign quo      = div_q[CH_W-1:0];
  assign quo_s    = $signed({2'b00, quo});
  assign lerp_c_sum = $signed({2'b00, a_ch}) + (neg ? -quo_s : quo_s);

  // Saturating add and subtract
  assign add_sum = {1'b0, a_ch} + {1'b0, b_ch};
  assign add_res = add_sum[CH_W] ? '1 : add_sum[CH_W-1:0];
  assign sub_res = (a_ch > b_ch) ? (a_ch - b_ch) : '0;

  // Select the lane result
  always_comb begin
    case (op)
      OP_ADD:    result_ch = add_res;
      OP_SUB:    result_ch = sub_res;
      OP_MUL:    result_ch = prod[15:8];
      OP_LERP_S: result_ch = lerp_s_res;
      OP_LERP_C: result_ch = lerp_c_sum[CH_W-1:0];
      OP_REPL:   result_ch = alpha_ch;
      default:   result_ch = a_ch;
    endcase
  end

endmodule
`default_nettype wire

FILE: src/rgba8_channel_alu.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rgba8_channel_alu: per-pixel combiner of packed RGBA8 colours
// Input register, four channel lanes, result register; one transaction per
// clock sustained while out_ch.ready stays high.
// ----------------------------------------------------------------------------
//  Channel   Dir   Handshake      Payload
//  in_ch     in    valid/ready    mode, first/second/factor colour, blend factor
//  out_ch    out   valid/ready    result_colour
//
//  An accepted transaction lands in the input register, then the lane result
//  is loaded into the result register, which raises result valid; throughput
//  is one transaction per cycle while out_ch.ready stays high, set by the
//  single pass through the lanes between the input and result registers.
//  Reset (rst_n low, synchronous) empties both register stages.
//  A stalled result holds in the result register; the input register still
//  takes a transaction while it is empty, then in_ch.ready drops.
// ----------------------------------------------------------------------------
module rgba8_channel_alu (
  input  wire logic  clk,
  input  wire logic  rst_n,
  rca_in_if.sink     in_ch,
  rca_out_if.source  out_ch
);
  import rca_pkg::*;

  logic    s1_v_r;
  logic    s1_v_nxt;
  mode_t   s1_mode_r;
  color_t  s1_a_r;
  color_t  s1_b_r;
  color_t  s1_c_r;
  factor_t s1_f_r;
  logic    out_v_r;
  logic    out_v_nxt;
  color_t  out_colour_r;
  color_t  lane_res;
  logic    adv;
  logic    in_take;

  // Advance stage 1 into the result register when that register frees up
  assign adv      = !out_v_r || out_ch.ready;
  assign in_ch.ready = !s1_v_r || adv;
  assign in_take  = in_ch.valid && in_ch.ready;

  assign s1_v_nxt  = in_take ? 1'b1 : (adv ? 1'b0 : s1_v_r);
  assign out_v_nxt = adv ? s1_v_r : out_v_r;

  // Hold stage valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  // Capture the input transaction
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_mode_r <= in_ch.mode;
      s1_a_r    <= in_ch.first_colour;
      s1_b_r    <= in_ch.second_colour;
      s1_c_r    <= in_ch.factor_colour;
      s1_f_r    <= in_ch.blend_factor;
    end
  end

  // Channel lanes
  for (genvar g = 0; g < LANES; g++) begin : g_lane
    rca_lane u_lane (
      .op           (rca_decode(s1_mode_r, LANE_W'(g))),
      .a_ch         (s1_a_r[g*CH_W +: CH_W]),
      .b_ch         (s1_b_r[g*CH_W +: CH_W]),
      .c_ch         (s1_c_r[g*CH_W +: CH_W]),
      .alpha_ch     (s1_a_r[LANE_ALPHA*CH_W +: CH_W]),
      .blend_factor (s1_f_r),
      .result_ch    (lane_res[g*CH_W +: CH_W])
    );
  end

  // Load the result register
  always_ff @(posedge clk) begin
    if (adv && s1_v_r) begin
      out_colour_r <= lane_res;
    end
  end

  assign out_ch.valid         = out_v_r;
  assign out_ch.result_colour = out_colour_r;

  // An accepted transaction always lands in stage 1
  a_take_lands: assert property (@(posedge clk) disable iff (!rst_n)
    in_take |=> s1_v_r)
    else $error("accepted transaction not held in input register");

  // A blocked stage 1 keeps its transaction
  a_s1_holds: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r && !adv |=> s1_v_r && $stable(s1_a_r) && $stable(s1_mode_r))
    else $error("stage 1 transaction lost while blocked");

  // Stage 1 moving forward produces a result
  a_s1_moves: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r && adv |=> out_v_r)
    else $error("stage 1 advanced without a result");

  // Both stages full and stalled: no new transaction taken
  a_full_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r && out_v_r && !out_ch.ready |-> !in_ch.ready)
    else $error("input accepted while pipeline full");

  // Empty result register never blocks the input
  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_v_r |-> in_ch.ready)
    else $error("input blocked with empty result register");

endmodule
`default_nettype wire
